FILE: design/tcd_pkg.sv
// Shared types for the tile change detector: register file contents,
// controller commands and datapath status. No dependencies.
package tcd_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int MAX_HEIGHT = 4096;

    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [8:0]  tile_size;
        logic [15:0] threshold_q8;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic accum;
        logic scale;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic tile_done;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

FILE: design/tcd_regs.sv
// APB-style register file for the tile change detector.
// Depends on tcd_pkg for the configuration struct and port widths.
module tcd_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tcd_pkg::ADDR_W-1:0] paddr,
    input  logic [tcd_pkg::DATA_W-1:0] pwdata,
    output logic [tcd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tcd_pkg::cfg_t              cfg
);

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE    = 2'd2;
    localparam logic [1:0] REG_THRESHOLD    = 2'd3;

    tcd_pkg::cfg_t cfg_reg;
    tcd_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = pwdata[12:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = pwdata[12:0];
                REG_TILE_SIZE:    cfg_next.tile_size    = pwdata[8:0];
                REG_THRESHOLD:    cfg_next.threshold_q8 = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 13'd4096;
            cfg_reg.image_height <= 13'd4096;
            cfg_reg.tile_size    <= 9'd32;
            cfg_reg.threshold_q8 <= 16'd7680;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_reg.image_height};
            REG_TILE_SIZE:    prdata = {23'd0, cfg_reg.tile_size};
            REG_THRESHOLD:    prdata = {16'd0, cfg_reg.threshold_q8};
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: design/tcd_ctrl.sv
// Controller state machine: sequences capture and accumulate for each pixel transaction,
// and threshold multiply and decision when it ends a tile. Depends on tcd_pkg.
module tcd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  tcd_pkg::stat_t stat,
    output tcd_pkg::ctrl_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCUM  = 4'b0010,
        ST_SCALE  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.tile_done ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stat.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/tcd_dpath.sv
// Datapath: raster position counters, column sum memory, saturating
// accumulate, threshold product, compare and output register. Uses tcd_pkg.
module tcd_dpath #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_TILE  = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tcd_pkg::cfg_t  cfg,
    input  tcd_pkg::ctrl_t cmd,
    output tcd_pkg::stat_t stat,
    input  logic [7:0]     cur_pixel,
    input  logic [7:0]     ref_pixel,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [11:0]    tile_x,
    output logic [11:0]    tile_y,
    output logic [8:0]     tile_w,
    output logic [8:0]     tile_h,
    output logic [23:0]    diff_sum
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int TW    = $clog2(MAX_TILE);
    localparam int TS_W  = $clog2(MAX_TILE + 1);
    localparam int XW    = (CW > 12) ? CW : 12;
    localparam int OW    = (TS_W > 9) ? TS_W : 9;
    localparam int M1W   = 16 + TS_W;
    localparam int PW    = M1W + TS_W;
    localparam int CMP_W = (PW > 32) ? PW : 32;

    logic [23:0]     sums_mem [MAX_WIDTH];

    logic [CW-1:0]   col_pos_reg;
    logic [CW-1:0]   col_pos_next;
    logic [11:0]     row_pos_reg;
    logic [11:0]     row_pos_next;
    logic [TW-1:0]   col_in_tile_reg;
    logic [TW-1:0]   col_in_tile_next;
    logic [TW-1:0]   row_in_tile_reg;
    logic [TW-1:0]   row_in_tile_next;
    logic [AW-1:0]   tile_column_reg;
    logic [AW-1:0]   tile_column_next;

    logic [CW-1:0]   w_eff;
    logic [12:0]     h_eff;
    logic [TS_W-1:0] ts_eff;
    logic            end_row;
    logic            last_row;
    logic            end_tcol;
    logic            end_trow;
    logic [TS_W-1:0] tw_cur;
    logic [TS_W-1:0] th_cur;
    logic [XW-1:0]   x_full;
    logic [7:0]      diff_cur;

    logic            done_reg;
    logic            first_reg;
    logic [7:0]      diff_reg;
    logic [AW-1:0]   idx_reg;
    logic [TS_W-1:0] tw_reg;
    logic [TS_W-1:0] th_reg;
    logic [11:0]     x_reg;
    logic [11:0]     y_reg;
    logic [23:0]     rd_data_reg;
    logic [23:0]     sum_reg;
    logic [M1W-1:0]  mul1_reg;
    logic [PW-1:0]   rhs_reg;

    logic [24:0]     sum_add;
    logic [23:0]     sum_new;
    logic [OW-1:0]   tw_ext;
    logic [OW-1:0]   th_ext;

    logic            out_valid_reg;
    logic [11:0]     tile_x_reg;
    logic [11:0]     tile_y_reg;
    logic [8:0]      tile_w_reg;
    logic [8:0]      tile_h_reg;
    logic [23:0]     diff_sum_reg;

    always_comb
    begin
        if (cfg.image_width == 13'd0)
            w_eff = CW'(1);
        else if (32'(cfg.image_width) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(cfg.image_width);

        if (cfg.image_height == 13'd0)
            h_eff = 13'd1;
        else if (32'(cfg.image_height) > tcd_pkg::MAX_HEIGHT)
            h_eff = 13'(tcd_pkg::MAX_HEIGHT);
        else
            h_eff = cfg.image_height;

        if (cfg.tile_size == 9'd0)
            ts_eff = TS_W'(1);
        else if (32'(cfg.tile_size) > MAX_TILE)
            ts_eff = TS_W'(MAX_TILE);
        else
            ts_eff = TS_W'(cfg.tile_size);
    end

    assign tw_cur   = TS_W'(col_in_tile_reg) + TS_W'(1);
    assign th_cur   = TS_W'(row_in_tile_reg) + TS_W'(1);
    assign end_row  = ((CW + 1)'(col_pos_reg) + (CW + 1)'(1)) >= (CW + 1)'(w_eff);
    assign last_row = ({1'b0, row_pos_reg} + 13'd1) >= h_eff;
    assign end_tcol = end_row || (tw_cur >= ts_eff);
    assign end_trow = last_row || (th_cur >= ts_eff);
    assign diff_cur = (cur_pixel > ref_pixel) ? (cur_pixel - ref_pixel)
                                              : (ref_pixel - cur_pixel);
    assign x_full   = XW'(col_pos_reg) - XW'(col_in_tile_reg);

    // Advance the raster and tile positions
    always_comb
    begin
        col_pos_next     = col_pos_reg;
        row_pos_next     = row_pos_reg;
        col_in_tile_next = col_in_tile_reg;
        row_in_tile_next = row_in_tile_reg;
        tile_column_next = tile_column_reg;
        if (cmd.capture)
        begin
            if (end_row)
            begin
                col_pos_next     = '0;
                col_in_tile_next = '0;
                tile_column_next = '0;
                if (last_row)
                begin
                    row_pos_next     = '0;
                    row_in_tile_next = '0;
                end
                else
                begin
                    row_pos_next     = row_pos_reg + 12'd1;
                    row_in_tile_next = end_trow ? '0 : TW'(th_cur);
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + CW'(1);
                if (end_tcol)
                begin
                    col_in_tile_next = '0;
                    tile_column_next = tile_column_reg + AW'(1);
                end
                else
                begin
                    col_in_tile_next = TW'(tw_cur);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            col_in_tile_reg <= '0;
            row_in_tile_reg <= '0;
            tile_column_reg <= '0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            col_pos_reg     <= col_pos_next;
            row_pos_reg     <= row_pos_next;
            col_in_tile_reg <= col_in_tile_next;
            row_in_tile_reg <= row_in_tile_next;
            tile_column_reg <= tile_column_next;
            if (cmd.capture)
                done_reg <= end_tcol && end_trow;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the transaction and read the running column sum
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            first_reg   <= (col_in_tile_reg == '0) && (row_in_tile_reg == '0);
            diff_reg    <= diff_cur;
            idx_reg     <= tile_column_reg;
            tw_reg      <= tw_cur;
            th_reg      <= th_cur;
            x_reg       <= x_full[11:0];
            y_reg       <= row_pos_reg - 12'(row_in_tile_reg);
            rd_data_reg <= sums_mem[tile_column_reg];
        end
    end

    assign sum_add = {1'b0, rd_data_reg} + 25'(diff_reg);
    assign sum_new = first_reg ? 24'(diff_reg)
                               : (sum_add[24] ? 24'hFFFFFF : sum_add[23:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            sums_mem[idx_reg] <= sum_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            sum_reg  <= sum_new;
            mul1_reg <= M1W'(cfg.threshold_q8) * M1W'(tw_reg);
        end
        if (cmd.scale)
        begin
            rhs_reg <= PW'(mul1_reg) * PW'(th_reg);
        end
    end

    assign tw_ext = OW'(tw_reg);
    assign th_ext = OW'(th_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tile_x_reg   <= x_reg;
            tile_y_reg   <= y_reg;
            tile_w_reg   <= tw_ext[8:0];
            tile_h_reg   <= th_ext[8:0];
            diff_sum_reg <= sum_reg;
        end
    end

    assign stat.tile_done = done_reg;
    assign stat.hit       = CMP_W'({sum_reg, 8'h00}) > CMP_W'(rhs_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign tile_x    = tile_x_reg;
    assign tile_y    = tile_y_reg;
    assign tile_w    = tile_w_reg;
    assign tile_h    = tile_h_reg;
    assign diff_sum  = diff_sum_reg;

    a_col_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(col_in_tile_reg) <= col_pos_reg)
        else $error("tile column offset ahead of pixel column");

    a_row_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        12'(row_in_tile_reg) <= row_pos_reg)
        else $error("tile row offset ahead of pixel row");

    a_tile_column: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(tile_column_reg) <= col_pos_reg)
        else $error("tile column index ahead of pixel column");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending transaction");

endmodule

FILE: design/tile_change_detector_core.sv
// Tile change detector top level: register file, controller and datapath.
// A pixel transaction passes through the capture and accumulate states; one that ends a
// tile also passes through scale and decide, where a hit waits on out_stall for the output
// register. in_stall holds off new pixels until the controller is idle. The states come
// from the sum memory read-then-write and the two-step threshold product. Reset clears
// positions, controller and output valid, loads register defaults, not the sum memory.
module tile_change_detector_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_TILE  = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tcd_pkg::ADDR_W-1:0] paddr,
    input  logic [tcd_pkg::DATA_W-1:0] pwdata,
    output logic [tcd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 cur_pixel,
    input  logic [7:0]                 ref_pixel,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [11:0]                tile_x,
    output logic [11:0]                tile_y,
    output logic [8:0]                 tile_w,
    output logic [8:0]                 tile_h,
    output logic [23:0]                diff_sum
);

    tcd_pkg::cfg_t  cfg;
    tcd_pkg::ctrl_t cmd;
    tcd_pkg::stat_t stat;

    tcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcd_dpath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TILE  (MAX_TILE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .cur_pixel (cur_pixel),
        .ref_pixel (ref_pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tile_x    (tile_x),
        .tile_y    (tile_y),
        .tile_w    (tile_w),
        .tile_h    (tile_h),
        .diff_sum  (diff_sum)
    );

endmodule
